// ----- rtl/tcasq_pkg.sv -----
// Package for the two-channel converter sample qualifier.
// Holds sample widths, register indexes, status codes and the shared structs.
// No dependencies.
package tcasq_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int MATCH_BITS = 2;
    localparam int MISMATCH_BITS = 5;
    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;
    localparam int REG_SEL_BITS = 2;

    localparam logic [REG_SEL_BITS-1:0] REG_VOLTAGE_HIGH = 2'd0;
    localparam logic [REG_SEL_BITS-1:0] REG_VOLTAGE_LOW  = 2'd1;
    localparam logic [REG_SEL_BITS-1:0] REG_CONNECT_LOW  = 2'd2;
    localparam logic [REG_SEL_BITS-1:0] REG_MISMATCH_LIM = 2'd3;

    localparam logic [SAMPLE_BITS-1:0] VOLTAGE_HIGH_RESET = SAMPLE_BITS'(512);
    localparam logic [SAMPLE_BITS-1:0] VOLTAGE_LOW_RESET  = SAMPLE_BITS'(256);
    localparam logic [SAMPLE_BITS-1:0] CONNECT_LOW_RESET  = SAMPLE_BITS'(200);
    localparam logic [MISMATCH_BITS-1:0] MISMATCH_LIM_RESET = MISMATCH_BITS'(30);

    localparam logic [MATCH_BITS-1:0] MATCH_TO_STORE = 2'd2;

    localparam logic [1:0] VST_CONVERTING = 2'd0;
    localparam logic [1:0] VST_BELOW      = 2'd1;
    localparam logic [1:0] VST_WITHIN     = 2'd2;
    localparam logic [1:0] VST_EXCEEDS    = 2'd3;

    localparam logic [1:0] CST_CONVERTING = 2'd0;
    localparam logic [1:0] CST_BELOW      = 2'd1;
    localparam logic [1:0] CST_WITHIN     = 2'd2;

    localparam logic CHAN_VOLTAGE = 1'b0;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0]   voltage_high;
        logic [SAMPLE_BITS-1:0]   voltage_low;
        logic [SAMPLE_BITS-1:0]   connect_low;
        logic [MISMATCH_BITS-1:0] mismatch_limit;
    } cfg_t;

    typedef struct packed {
        logic                   sampled_channel;
        logic                   accepted;
        logic                   timed_out;
        logic [1:0]             voltage_status;
        logic [1:0]             connection_status;
        logic [SAMPLE_BITS-1:0] voltage_value;
        logic [SAMPLE_BITS-1:0] connection_value;
    } result_t;

endpackage

// ----- rtl/tcasq_regs.sv -----
// Configuration register file for the sample qualifier, written over APB.
// Depends on tcasq_pkg for register indexes, reset values and cfg_t.
module tcasq_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tcasq_pkg::ADDR_BITS-1:0] paddr,
    input  logic [tcasq_pkg::DATA_BITS-1:0] pwdata,
    output logic [tcasq_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    output tcasq_pkg::cfg_t                cfg
);

    tcasq_pkg::cfg_t cfg_reg;
    tcasq_pkg::cfg_t cfg_next;
    logic [tcasq_pkg::REG_SEL_BITS-1:0] sel;
    logic wr_en;

    assign sel = paddr[tcasq_pkg::ADDR_BITS-1:2];
    assign wr_en = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (sel)
                tcasq_pkg::REG_VOLTAGE_HIGH:
                    cfg_next.voltage_high = pwdata[tcasq_pkg::SAMPLE_BITS-1:0];
                tcasq_pkg::REG_VOLTAGE_LOW:
                    cfg_next.voltage_low = pwdata[tcasq_pkg::SAMPLE_BITS-1:0];
                tcasq_pkg::REG_CONNECT_LOW:
                    cfg_next.connect_low = pwdata[tcasq_pkg::SAMPLE_BITS-1:0];
                tcasq_pkg::REG_MISMATCH_LIM:
                    cfg_next.mismatch_limit = pwdata[tcasq_pkg::MISMATCH_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            tcasq_pkg::REG_VOLTAGE_HIGH:
                prdata = tcasq_pkg::DATA_BITS'(cfg_reg.voltage_high);
            tcasq_pkg::REG_VOLTAGE_LOW:
                prdata = tcasq_pkg::DATA_BITS'(cfg_reg.voltage_low);
            tcasq_pkg::REG_CONNECT_LOW:
                prdata = tcasq_pkg::DATA_BITS'(cfg_reg.connect_low);
            tcasq_pkg::REG_MISMATCH_LIM:
                prdata = tcasq_pkg::DATA_BITS'(cfg_reg.mismatch_limit);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.voltage_high   <= tcasq_pkg::VOLTAGE_HIGH_RESET;
            cfg_reg.voltage_low    <= tcasq_pkg::VOLTAGE_LOW_RESET;
            cfg_reg.connect_low    <= tcasq_pkg::CONNECT_LOW_RESET;
            cfg_reg.mismatch_limit <= tcasq_pkg::MISMATCH_LIM_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/tcasq_core.sv -----
// Qualifier state and per-item update logic: match and mismatch counting,
// channel selection, stored readings and status classification.
// Depends on tcasq_pkg for widths, status codes, cfg_t and result_t.
module tcasq_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             take,
    input  logic [tcasq_pkg::SAMPLE_BITS-1:0] reading,
    input  tcasq_pkg::cfg_t                  cfg,
    output tcasq_pkg::result_t               result
);

    logic                               chan_reg, chan_next;
    logic [tcasq_pkg::SAMPLE_BITS-1:0]  prev_reg, prev_next;
    logic [tcasq_pkg::MATCH_BITS-1:0]   match_reg, match_next;
    logic [tcasq_pkg::MISMATCH_BITS-1:0] mis_reg, mis_next;
    logic [tcasq_pkg::SAMPLE_BITS-1:0]  volt_reg, volt_next;
    logic                               volt_known_reg, volt_known_next;
    logic [tcasq_pkg::SAMPLE_BITS-1:0]  conn_reg, conn_next;
    logic                               conn_known_reg, conn_known_next;

    logic                               same;
    logic                               store;
    logic                               give_up;
    logic [tcasq_pkg::MISMATCH_BITS-1:0] mis_after;

    assign same = (reading == prev_reg);
    assign store = same && (match_reg == tcasq_pkg::MATCH_TO_STORE);
    assign mis_after = same ? mis_reg : mis_reg + 1'b1;
    assign give_up = !store && (mis_after >= cfg.mismatch_limit);

    always_comb
    begin
        chan_next = chan_reg;
        prev_next = prev_reg;
        match_next = match_reg;
        mis_next = mis_reg;
        volt_next = volt_reg;
        volt_known_next = volt_known_reg;
        conn_next = conn_reg;
        conn_known_next = conn_known_reg;
        if (store)
        begin
            if (chan_reg == tcasq_pkg::CHAN_VOLTAGE)
            begin
                volt_next = reading;
                volt_known_next = 1'b1;
            end
            else
            begin
                conn_next = reading;
                conn_known_next = 1'b1;
            end
            chan_next = ~chan_reg;
            match_next = '0;
            mis_next = '0;
        end
        else if (give_up)
        begin
            prev_next = reading;
            chan_next = ~chan_reg;
            match_next = '0;
            mis_next = '0;
        end
        else if (same)
        begin
            match_next = match_reg + 1'b1;
        end
        else
        begin
            prev_next = reading;
            match_next = '0;
            mis_next = mis_after;
        end
    end

    always_comb
    begin
        result.sampled_channel = chan_reg;
        result.accepted = store;
        result.timed_out = give_up;
        result.voltage_value = volt_next;
        result.connection_value = conn_next;
        if (!volt_known_next)
        begin
            result.voltage_status = tcasq_pkg::VST_CONVERTING;
        end
        else if (volt_next >= cfg.voltage_high)
        begin
            result.voltage_status = tcasq_pkg::VST_EXCEEDS;
        end
        else if (volt_next >= cfg.voltage_low)
        begin
            result.voltage_status = tcasq_pkg::VST_WITHIN;
        end
        else
        begin
            result.voltage_status = tcasq_pkg::VST_BELOW;
        end
        if (!conn_known_next)
        begin
            result.connection_status = tcasq_pkg::CST_CONVERTING;
        end
        else if (conn_next < cfg.connect_low)
        begin
            result.connection_status = tcasq_pkg::CST_BELOW;
        end
        else
        begin
            result.connection_status = tcasq_pkg::CST_WITHIN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg <= tcasq_pkg::CHAN_VOLTAGE;
            prev_reg <= '0;
            match_reg <= '0;
            mis_reg <= '0;
            volt_reg <= '0;
            volt_known_reg <= 1'b0;
            conn_reg <= '0;
            conn_known_reg <= 1'b0;
        end
        else if (take)
        begin
            chan_reg <= chan_next;
            prev_reg <= prev_next;
            match_reg <= match_next;
            mis_reg <= mis_next;
            volt_reg <= volt_next;
            volt_known_reg <= volt_known_next;
            conn_reg <= conn_next;
            conn_known_reg <= conn_known_next;
        end
    end

endmodule

// ----- rtl/two_channel_adc_sample_qualifier.sv -----
// Top level of the two-channel converter sample qualifier: input register,
// result register and the APB configuration port.
// Depends on tcasq_pkg, tcasq_regs and tcasq_core.
//
//   channel | handshake              | payload
//   --------+------------------------+----------------------------------------
//   in      | in_valid / in_stall    | reading
//   out     | out_valid / out_stall  | sampled_channel, accepted, timed_out,
//           |                        | voltage_status, connection_status,
//           |                        | voltage_value, connection_value
//   config  | psel, penable, pwrite  | paddr, pwdata, prdata, pready
//
// Each item is held in the input register and then moves into the result
// register once that register is free. One item is accepted per cycle while
// in_stall is low; the state update in the core sets that figure.
// Reset clears the qualifier state and loads the register defaults.
// While a result is stalled the input register takes one more item; in_stall
// then stays high until out_stall drops.
module two_channel_adc_sample_qualifier
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [tcasq_pkg::SAMPLE_BITS-1:0] reading,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             sampled_channel,
    output logic                             accepted,
    output logic                             timed_out,
    output logic [1:0]                       voltage_status,
    output logic [1:0]                       connection_status,
    output logic [tcasq_pkg::SAMPLE_BITS-1:0] voltage_value,
    output logic [tcasq_pkg::SAMPLE_BITS-1:0] connection_value,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tcasq_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [tcasq_pkg::DATA_BITS-1:0]  pwdata,
    output logic [tcasq_pkg::DATA_BITS-1:0]  prdata,
    output logic                             pready
);

    tcasq_pkg::cfg_t                   cfg;
    tcasq_pkg::result_t                result;
    tcasq_pkg::result_t                out_reg;
    logic                              in_valid_reg;
    logic [tcasq_pkg::SAMPLE_BITS-1:0] in_data_reg;
    logic                              out_valid_reg;
    logic                              out_free;
    logic                              advance;
    logic                              take_in;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign take_in = in_valid && !in_stall;

    tcasq_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tcasq_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (advance),
        .reading (in_data_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take_in)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_data_reg <= reading;
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign sampled_channel = out_reg.sampled_channel;
    assign accepted = out_reg.accepted;
    assign timed_out = out_reg.timed_out;
    assign voltage_status = out_reg.voltage_status;
    assign connection_status = out_reg.connection_status;
    assign voltage_value = out_reg.voltage_value;
    assign connection_value = out_reg.connection_value;

endmodule

// ----- sim/tb.sv -----
// Testbench for the two-channel converter sample qualifier: directed, random and
// backpressure tests checked against an in-bench predictor of the qualifier.
// Depends on tcasq_pkg and two_channel_adc_sample_qualifier.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic [tcasq_pkg::SAMPLE_BITS-1:0]   reading = '0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic                                sampled_channel;
    logic                                accepted;
    logic                                timed_out;
    logic [1:0]                          voltage_status;
    logic [1:0]                          connection_status;
    logic [tcasq_pkg::SAMPLE_BITS-1:0]   voltage_value;
    logic [tcasq_pkg::SAMPLE_BITS-1:0]   connection_value;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [tcasq_pkg::ADDR_BITS-1:0]     paddr = '0;
    logic [tcasq_pkg::DATA_BITS-1:0]     pwdata = '0;
    logic [tcasq_pkg::DATA_BITS-1:0]     prdata;
    logic                                pready;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic hold_active = 1'b0;

    logic [tcasq_pkg::SAMPLE_BITS-1:0]   vh_thresh = tcasq_pkg::VOLTAGE_HIGH_RESET;
    logic [tcasq_pkg::SAMPLE_BITS-1:0]   vl_thresh = tcasq_pkg::VOLTAGE_LOW_RESET;
    logic [tcasq_pkg::SAMPLE_BITS-1:0]   cl_thresh = tcasq_pkg::CONNECT_LOW_RESET;
    logic [tcasq_pkg::MISMATCH_BITS-1:0] mlim = tcasq_pkg::MISMATCH_LIM_RESET;

    logic                                chan_sel = tcasq_pkg::CHAN_VOLTAGE;
    logic [tcasq_pkg::SAMPLE_BITS-1:0]   prev_reading = '0;
    logic [tcasq_pkg::MATCH_BITS-1:0]    match_cnt = '0;
    logic [tcasq_pkg::MISMATCH_BITS-1:0] mismatch_cnt = '0;
    logic [tcasq_pkg::SAMPLE_BITS-1:0]   volt_store = '0;
    logic                                volt_known = 1'b0;
    logic [tcasq_pkg::SAMPLE_BITS-1:0]   conn_store = '0;
    logic                                conn_known = 1'b0;

    tcasq_pkg::result_t expected_results[$];

    int error_count = 0;
    int items_in = 0;
    int results_seen = 0;
    int stores_seen = 0;
    int timeouts_seen = 0;
    int settings_used = 1;
    int quiet_cycles = 0;

    two_channel_adc_sample_qualifier u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .reading           (reading),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .sampled_channel   (sampled_channel),
        .accepted          (accepted),
        .timed_out         (timed_out),
        .voltage_status    (voltage_status),
        .connection_status (connection_status),
        .voltage_value     (voltage_value),
        .connection_value  (connection_value),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #1 clk = ~clk;

    function automatic tcasq_pkg::result_t qualify_reading(
        input logic [tcasq_pkg::SAMPLE_BITS-1:0] r);
        tcasq_pkg::result_t res;
        res = '0;
        res.sampled_channel = chan_sel;
        if (r == prev_reading && match_cnt == tcasq_pkg::MATCH_TO_STORE)
        begin
            if (chan_sel == tcasq_pkg::CHAN_VOLTAGE)
            begin
                volt_store = r;
                volt_known = 1'b1;
            end
            else
            begin
                conn_store = r;
                conn_known = 1'b1;
            end
            chan_sel = ~chan_sel;
            match_cnt = '0;
            mismatch_cnt = '0;
            res.accepted = 1'b1;
        end
        else
        begin
            if (r == prev_reading)
                match_cnt = match_cnt + 1'b1;
            else
            begin
                prev_reading = r;
                match_cnt = '0;
                mismatch_cnt = mismatch_cnt + 1'b1;
            end
            if (mismatch_cnt >= mlim)
            begin
                chan_sel = ~chan_sel;
                match_cnt = '0;
                mismatch_cnt = '0;
                res.timed_out = 1'b1;
            end
        end
        if (!volt_known)
            res.voltage_status = tcasq_pkg::VST_CONVERTING;
        else if (volt_store >= vh_thresh)
            res.voltage_status = tcasq_pkg::VST_EXCEEDS;
        else if (volt_store >= vl_thresh)
            res.voltage_status = tcasq_pkg::VST_WITHIN;
        else
            res.voltage_status = tcasq_pkg::VST_BELOW;
        if (!conn_known)
            res.connection_status = tcasq_pkg::CST_CONVERTING;
        else if (conn_store < cl_thresh)
            res.connection_status = tcasq_pkg::CST_BELOW;
        else
            res.connection_status = tcasq_pkg::CST_WITHIN;
        res.voltage_value = volt_store;
        res.connection_value = conn_store;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int unsigned expv,
                                   input int unsigned gotv);
        $display("ERROR at %0t: result %0d, %s: expected %0d, got %0d",
                 $realtime, results_seen, field, expv, gotv);
        error_count++;
    endtask

    task automatic check_result();
        tcasq_pkg::result_t want;
        if (expected_results.size() == 0)
            report_mismatch("result with no item pending", 0, 1);
        else
        begin
            want = expected_results.pop_front();
            if (sampled_channel !== want.sampled_channel)
                report_mismatch("sampled_channel", want.sampled_channel, sampled_channel);
            if (accepted !== want.accepted)
                report_mismatch("accepted", want.accepted, accepted);
            if (timed_out !== want.timed_out)
                report_mismatch("timed_out", want.timed_out, timed_out);
            if (voltage_status !== want.voltage_status)
                report_mismatch("voltage_status", want.voltage_status, voltage_status);
            if (connection_status !== want.connection_status)
                report_mismatch("connection_status", want.connection_status,
                                connection_status);
            if (voltage_value !== want.voltage_value)
                report_mismatch("voltage_value", want.voltage_value, voltage_value);
            if (connection_value !== want.connection_value)
                report_mismatch("connection_value", want.connection_value,
                                connection_value);
        end
        results_seen++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(qualify_reading(reading));
                stores_seen += expected_results[$].accepted;
                timeouts_seen += expected_results[$].timed_out;
                items_in++;
            end
            if (out_valid && !out_stall)
                check_result();
        end
    end

    always @(posedge clk)
        out_stall <= hold_active || ($urandom_range(0, 99) < recv_idle_pct);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no item moved for %0d cycles.", STALL_LIMIT);
            $display("two_channel_adc_sample_qualifier: mismatch");
            $finish;
        end
    end

    task automatic send_reading(input logic [tcasq_pkg::SAMPLE_BITS-1:0] r);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        reading <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_burst(input logic [tcasq_pkg::SAMPLE_BITS-1:0] r, input int len);
        repeat (len)
            send_reading(r);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [tcasq_pkg::REG_SEL_BITS-1:0] idx,
                             input logic [tcasq_pkg::DATA_BITS-1:0] value);
        logic [tcasq_pkg::DATA_BITS-1:0] data;
        data = value | ($urandom() << ((idx == tcasq_pkg::REG_MISMATCH_LIM)
                                       ? tcasq_pkg::MISMATCH_BITS
                                       : tcasq_pkg::SAMPLE_BITS));
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            tcasq_pkg::REG_VOLTAGE_HIGH: vh_thresh = data[tcasq_pkg::SAMPLE_BITS-1:0];
            tcasq_pkg::REG_VOLTAGE_LOW:  vl_thresh = data[tcasq_pkg::SAMPLE_BITS-1:0];
            tcasq_pkg::REG_CONNECT_LOW:  cl_thresh = data[tcasq_pkg::SAMPLE_BITS-1:0];
            default:                     mlim = data[tcasq_pkg::MISMATCH_BITS-1:0];
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [tcasq_pkg::SAMPLE_BITS-1:0] pick_threshold();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            default: return tcasq_pkg::SAMPLE_BITS'($urandom());
        endcase
    endfunction

    task automatic randomize_config();
        int lim;
        case ($urandom_range(0, 4))
            0:       lim = 1;
            1:       lim = 31;
            default: lim = $urandom_range(1, 31);
        endcase
        write_reg(tcasq_pkg::REG_VOLTAGE_HIGH, tcasq_pkg::DATA_BITS'(pick_threshold()));
        write_reg(tcasq_pkg::REG_VOLTAGE_LOW, tcasq_pkg::DATA_BITS'(pick_threshold()));
        write_reg(tcasq_pkg::REG_CONNECT_LOW, tcasq_pkg::DATA_BITS'(pick_threshold()));
        write_reg(tcasq_pkg::REG_MISMATCH_LIM, lim);
        settings_used++;
    endtask

    function automatic logic [tcasq_pkg::SAMPLE_BITS-1:0] pick_reading();
        case ($urandom_range(0, 7))
            0:       return vh_thresh + tcasq_pkg::SAMPLE_BITS'($urandom_range(0, 2)) - 1'b1;
            1:       return vl_thresh + tcasq_pkg::SAMPLE_BITS'($urandom_range(0, 2)) - 1'b1;
            2:       return cl_thresh + tcasq_pkg::SAMPLE_BITS'($urandom_range(0, 2)) - 1'b1;
            3:       return ($urandom_range(0, 1) != 0) ? '1 : '0;
            default: return tcasq_pkg::SAMPLE_BITS'($urandom());
        endcase
    endfunction

    task automatic send_random_items(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                len = $urandom_range(3, 5);
                send_burst(pick_reading(), len);
            end
            else
            begin
                len = $urandom_range(1, 3);
                repeat (len)
                    send_reading(tcasq_pkg::SAMPLE_BITS'($urandom()));
            end
            sent += len;
        end
    endtask

    task automatic test_first_reading_and_shared_previous();
        send_burst('0, 3);
        send_burst('1, 4);
        send_burst('1, 3);
        send_burst(tcasq_pkg::SAMPLE_BITS'(199), 4);
    endtask

    task automatic test_limit_and_threshold_corners();
        wait_idle();
        write_reg(tcasq_pkg::REG_MISMATCH_LIM, 0);
        write_reg(tcasq_pkg::REG_VOLTAGE_HIGH, 100);
        write_reg(tcasq_pkg::REG_VOLTAGE_LOW, 900);
        write_reg(tcasq_pkg::REG_CONNECT_LOW, 1023);
        settings_used++;
        send_reading(tcasq_pkg::SAMPLE_BITS'(5));
        send_reading(tcasq_pkg::SAMPLE_BITS'(6));
        send_reading(tcasq_pkg::SAMPLE_BITS'(6));
        wait_idle();
        write_reg(tcasq_pkg::REG_MISMATCH_LIM, 31);
        settings_used++;
        send_burst(tcasq_pkg::SAMPLE_BITS'(50), 4);
        send_burst(tcasq_pkg::SAMPLE_BITS'(60), 4);
    endtask

    task automatic test_random_phase(input int n_items, input int spct, input int rpct);
        wait_idle();
        randomize_config();
        send_idle_pct = spct;
        recv_idle_pct = rpct;
        send_random_items(n_items);
    endtask

    task automatic test_backpressure();
        wait_idle();
        randomize_config();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            begin
                hold_active <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                hold_active <= 1'b0;
            end
            send_random_items(40);
        join
    endtask

    initial
    begin
        send_idle_pct = 8;
        recv_idle_pct = 71;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_reading_and_shared_previous();
        test_limit_and_threshold_corners();
        test_random_phase(125, 8, 71);
        test_random_phase(125, 8, 71);
        test_random_phase(125, 71, 8);
        test_random_phase(125, 71, 8);
        test_random_phase(125, 0, 0);
        test_random_phase(125, 0, 0);
        test_backpressure();
        wait_idle();
        repeat (8)
            @(posedge clk);

        $display("Sent %0d readings under %0d register settings; checked %0d results.",
                 items_in, settings_used, results_seen);
        $display("Predicted %0d stored readings and %0d channel timeouts; %0d errors.",
                 stores_seen, timeouts_seen, error_count);
        if (error_count == 0 && expected_results.size() == 0)
            $display("two_channel_adc_sample_qualifier: match");
        else
            $display("two_channel_adc_sample_qualifier: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/tcasq_pkg.sv
rtl/tcasq_regs.sv
rtl/tcasq_core.sv
rtl/two_channel_adc_sample_qualifier.sv
sim/tb.sv
